/* src/fwcrr_pkg.sv */
// ----------------------------------------------------------------------------
// fwcrr_pkg
// Shared types and constants of the frame crop, roll and resize engine.
// ----------------------------------------------------------------------------
package fwcrr_pkg;

    localparam int CFG_W      = 7;
    localparam int OFF_W      = 6;
    localparam int MODE_W     = 2;
    localparam int POS_W      = 6;
    localparam int COORD_W    = 7;
    localparam int IDX_W      = 14;
    localparam int DIV_N      = 14;
    localparam int DIV_D      = 7;
    localparam int DIV_CNT_W  = 4;
    localparam int PIX_PORT_W = 32;
    localparam int PADDR_W    = 5;
    localparam int PDATA_W    = 32;
    localparam int REG_IDX_W  = 3;

    localparam logic [REG_IDX_W-1:0] REG_MODE       = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_SRC_WIDTH  = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_SRC_HEIGHT = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_OUT_WIDTH  = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_OUT_HEIGHT = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_OFFSET_X   = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_OFFSET_Y   = 3'd6;

    localparam logic [MODE_W-1:0] MODE_RESIZE = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ROLL   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CROP   = 2'd2;
    localparam int                MODE_CROP_BIT = 1;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_FETCH = 1'b1;

    localparam logic [MODE_W-1:0] RST_MODE   = MODE_RESIZE;
    localparam logic [CFG_W-1:0]  RST_SIZE   = 7'd64;
    localparam logic [OFF_W-1:0]  RST_OFFSET = 6'd0;

    typedef enum logic [1:0] {
        STAT_PIXEL      = 2'd0,
        STAT_LOADED     = 2'd1,
        STAT_INCOMPLETE = 2'd2,
        STAT_INVALID    = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        K_WRITE = 2'd0,
        K_READ  = 2'd1,
        K_FLAG  = 2'd2
    } t_kind;

    typedef struct packed {
        t_kind              kind;
        logic [POS_W-1:0]   x;
        logic [POS_W-1:0]   y;
        logic               last;
        t_status            status;
    } t_meta;

    localparam int META_W = $bits(t_meta);

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [CFG_W-1:0]  src_width;
        logic [CFG_W-1:0]  src_height;
        logic [CFG_W-1:0]  out_width;
        logic [CFG_W-1:0]  out_height;
        logic [OFF_W-1:0]  offset_x;
        logic [OFF_W-1:0]  offset_y;
    } t_cfg;

    typedef enum logic [2:0] {
        FS_IDLE = 3'd0,
        FS_XS   = 3'd1,
        FS_XW   = 3'd2,
        FS_YS   = 3'd3,
        FS_YW   = 3'd4,
        FS_PUSH = 3'd5
    } t_fstate;

endpackage

/* src/fwcrr_div.sv */
// ----------------------------------------------------------------------------
// fwcrr_div
// Restoring divider, one quotient bit per cycle, quotient and remainder.
// ----------------------------------------------------------------------------
module fwcrr_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [fwcrr_pkg::DIV_N-1:0] i_dividend,
    input  logic [fwcrr_pkg::DIV_D-1:0] i_divisor,
    output logic                        o_done,
    output logic [fwcrr_pkg::DIV_N-1:0] o_quotient,
    output logic [fwcrr_pkg::DIV_D-1:0] o_remainder
);
    import fwcrr_pkg::*;

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DIV_N-1:0]     r_quo;
    logic [DIV_D-1:0]     r_rem;
    logic [DIV_D-1:0]     r_div;
    logic [DIV_D:0]       trial;
    logic [DIV_D:0]       diff;
    logic                 ge;

    assign trial = {r_rem, r_quo[DIV_N-1]};
    assign ge    = trial >= {1'b0, r_div};
    assign diff  = trial - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_CNT_W'(DIV_N - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_rem <= ge ? diff[DIV_D-1:0] : trial[DIV_D-1:0];
            r_quo <= {r_quo[DIV_N-2:0], ge};
        end
    end

    assign o_done      = r_done;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

endmodule

/* src/fwcrr_front.sv */
// ----------------------------------------------------------------------------
// fwcrr_front
// Accepts loads and fetches, keeps the frame and position counters and
// works out the store address of each request.
// ----------------------------------------------------------------------------
module fwcrr_front #(
    parameter int MAX_WIDTH  = 64,
    parameter int MAX_HEIGHT = 64,
    parameter int ADDR_W     = 12,
    parameter int PIXEL_BITS = 32
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  fwcrr_pkg::t_cfg                  i_cfg,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic                             i_operation,
    input  logic [fwcrr_pkg::PIX_PORT_W-1:0] i_pixel_in,
    output logic                             o_push,
    output fwcrr_pkg::t_meta                 o_meta,
    output logic [ADDR_W-1:0]                o_addr,
    output logic [PIXEL_BITS-1:0]            o_pix,
    input  logic                             i_full
);
    import fwcrr_pkg::*;

    function automatic logic [CFG_W-1:0] clamp_src(input logic [CFG_W-1:0] v, input int mx);
        if (v == '0) begin
            return CFG_W'(1);
        end else if (int'(v) > mx) begin
            return CFG_W'(mx);
        end
        return v;
    endfunction

    function automatic logic [CFG_W-1:0] clamp_out(input logic [CFG_W-1:0] v, input int mx);
        if (int'(v) > mx) begin
            return CFG_W'(mx);
        end
        return v;
    endfunction

    t_fstate              r_state, n_state;
    logic [IDX_W-1:0]     r_count, n_count;
    logic                 r_ready, n_ready;
    logic [COORD_W-1:0]   r_col, n_col;
    logic [COORD_W-1:0]   r_row, n_row;
    logic [COORD_W-1:0]   r_cx, n_cx;
    logic [COORD_W-1:0]   r_cy, n_cy;
    logic                 r_last, n_last;
    logic [COORD_W-1:0]   r_sx, n_sx;
    logic [COORD_W-1:0]   r_sy, n_sy;

    logic [CFG_W-1:0]     sw, sh, ow_c, oh_c, ow, oh;
    logic                 is_crop, is_roll, fetch_bad, wrap, last;
    logic [IDX_W-1:0]     size, load_base, load_next, rd_idx;
    logic [IDX_W+ADDR_W-1:0] load_wide, rd_wide;
    logic [COORD_W-1:0]   cx, cy, crop_sx, crop_sy;
    logic                 accept;

    logic                 div_start, div_done;
    logic [DIV_N-1:0]     div_dividend, div_quo;
    logic [DIV_D-1:0]     div_divisor, div_rem;

    assign sw      = clamp_src(i_cfg.src_width, MAX_WIDTH);
    assign sh      = clamp_src(i_cfg.src_height, MAX_HEIGHT);
    assign ow_c    = clamp_out(i_cfg.out_width, MAX_WIDTH);
    assign oh_c    = clamp_out(i_cfg.out_height, MAX_HEIGHT);
    assign is_crop = i_cfg.mode[MODE_CROP_BIT];
    assign is_roll = (i_cfg.mode == MODE_ROLL);
    assign ow      = is_roll ? sw : ow_c;
    assign oh      = is_roll ? sh : oh_c;

    assign fetch_bad = is_crop
        ? (ow == '0 || oh == '0
           || ({2'b0, i_cfg.offset_x} + {1'b0, ow}) > {1'b0, sw}
           || ({2'b0, i_cfg.offset_y} + {1'b0, oh}) > {1'b0, sh})
        : (!is_roll && (ow == '0 || oh == '0));

    assign size      = IDX_W'(sw) * IDX_W'(sh);
    assign load_base = (r_ready || r_count >= size) ? '0 : r_count;
    assign load_next = load_base + 1'b1;
    assign load_wide = {{ADDR_W{1'b0}}, load_base};

    assign wrap    = (r_col >= ow) || (r_row >= oh);
    assign cx      = wrap ? '0 : r_col;
    assign cy      = wrap ? '0 : r_row;
    assign last    = ({1'b0, cx} + 1'b1 == {1'b0, ow}) && ({1'b0, cy} + 1'b1 == {1'b0, oh});
    assign crop_sx = COORD_W'({1'b0, cx} + {2'b0, i_cfg.offset_x});
    assign crop_sy = COORD_W'({1'b0, cy} + {2'b0, i_cfg.offset_y});

    assign rd_idx  = IDX_W'(r_sy) * IDX_W'(sw) + IDX_W'(r_sx);
    assign rd_wide = {{ADDR_W{1'b0}}, rd_idx};

    assign accept = i_in_valid && !o_in_stall;

    fwcrr_div u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (div_start),
        .i_dividend  (div_dividend),
        .i_divisor   (div_divisor),
        .o_done      (div_done),
        .o_quotient  (div_quo),
        .o_remainder (div_rem)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= FS_IDLE;
            r_count <= '0;
            r_ready <= 1'b0;
            r_col   <= '0;
            r_row   <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_ready <= n_ready;
            r_col   <= n_col;
            r_row   <= n_row;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cx   <= n_cx;
        r_cy   <= n_cy;
        r_last <= n_last;
        r_sx   <= n_sx;
        r_sy   <= n_sy;
    end

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_ready      = r_ready;
        n_col        = r_col;
        n_row        = r_row;
        n_cx         = r_cx;
        n_cy         = r_cy;
        n_last       = r_last;
        n_sx         = r_sx;
        n_sy         = r_sy;
        o_in_stall   = 1'b1;
        o_push       = 1'b0;
        o_meta       = '{kind: K_FLAG, x: '0, y: '0, last: 1'b0, status: STAT_PIXEL};
        o_addr       = load_wide[ADDR_W-1:0];
        o_pix        = i_pixel_in[PIXEL_BITS-1:0];
        div_start    = 1'b0;
        div_dividend = '0;
        div_divisor  = '0;

        case (r_state)
            FS_IDLE: begin
                o_in_stall = i_full;
                if (accept) begin
                    if (i_operation == OP_LOAD) begin
                        o_push      = 1'b1;
                        o_meta.kind   = K_WRITE;
                        o_meta.status = STAT_LOADED;
                        n_ready = (load_next >= size);
                        n_count = (load_next >= size) ? '0 : load_next;
                        n_col   = '0;
                        n_row   = '0;
                    end else if (!r_ready) begin
                        o_push        = 1'b1;
                        o_meta.status = STAT_INCOMPLETE;
                    end else if (fetch_bad) begin
                        o_push        = 1'b1;
                        o_meta.status = STAT_INVALID;
                    end else begin
                        n_cx   = cx;
                        n_cy   = cy;
                        n_last = last;
                        if (last) begin
                            n_col = '0;
                            n_row = '0;
                        end else if ({1'b0, cx} + 1'b1 >= {1'b0, ow}) begin
                            n_col = '0;
                            n_row = cy + 1'b1;
                        end else begin
                            n_col = cx + 1'b1;
                            n_row = cy;
                        end
                        if (is_crop) begin
                            n_sx    = crop_sx;
                            n_sy    = crop_sy;
                            n_state = FS_PUSH;
                        end else begin
                            n_state = FS_XS;
                        end
                    end
                end
            end
            FS_XS: begin
                div_start = 1'b1;
                if (is_roll) begin
                    div_dividend = DIV_N'(r_cx) + DIV_N'(i_cfg.offset_x);
                    div_divisor  = sw;
                end else begin
                    div_dividend = DIV_N'(r_cx) * DIV_N'(sw);
                    div_divisor  = ow;
                end
                n_state = FS_XW;
            end
            FS_XW: begin
                if (div_done) begin
                    n_sx    = is_roll ? div_rem : div_quo[COORD_W-1:0];
                    n_state = FS_YS;
                end
            end
            FS_YS: begin
                div_start = 1'b1;
                if (is_roll) begin
                    div_dividend = DIV_N'(r_cy) + DIV_N'(i_cfg.offset_y);
                    div_divisor  = sh;
                end else begin
                    div_dividend = DIV_N'(r_cy) * DIV_N'(sh);
                    div_divisor  = oh;
                end
                n_state = FS_YW;
            end
            FS_YW: begin
                if (div_done) begin
                    n_sy    = is_roll ? div_rem : div_quo[COORD_W-1:0];
                    n_state = FS_PUSH;
                end
            end
            FS_PUSH: begin
                o_addr = rd_wide[ADDR_W-1:0];
                if (!i_full) begin
                    o_push = 1'b1;
                    o_meta = '{kind: K_READ, x: r_cx[POS_W-1:0], y: r_cy[POS_W-1:0],
                               last: r_last, status: STAT_PIXEL};
                    n_state = FS_IDLE;
                end
            end
            default: begin
                n_state = FS_IDLE;
            end
        endcase
    end

endmodule

/* src/fwcrr_queue.sv */
// ----------------------------------------------------------------------------
// fwcrr_queue
// Short request queue between the front and the back.
// ----------------------------------------------------------------------------
module fwcrr_queue #(
    parameter int W     = 64,
    parameter int DEPTH = 4
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    output logic         o_full,
    input  logic         i_pop,
    output logic [W-1:0] o_data,
    output logic         o_empty
);
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [W-1:0]     r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [CNT_W-1:0] r_cnt;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

/* src/fwcrr_back.sv */
// ----------------------------------------------------------------------------
// fwcrr_back
// Carries out requests on the frame store and holds the result register.
// ----------------------------------------------------------------------------
module fwcrr_back #(
    parameter int ADDR_W     = 12,
    parameter int PIXEL_BITS = 32,
    parameter int DEPTH      = 4096
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_empty,
    input  fwcrr_pkg::t_meta                 i_meta,
    input  logic [ADDR_W-1:0]                i_addr,
    input  logic [PIXEL_BITS-1:0]            i_pix,
    output logic                             o_pop,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic [fwcrr_pkg::PIX_PORT_W-1:0] o_pixel_out,
    output logic [fwcrr_pkg::POS_W-1:0]      o_out_x,
    output logic [fwcrr_pkg::POS_W-1:0]      o_out_y,
    output logic                             o_last_pixel,
    output logic [1:0]                       o_status
);
    import fwcrr_pkg::*;

    logic [PIXEL_BITS-1:0] r_store [DEPTH];
    logic [PIXEL_BITS-1:0] r_rd;
    t_meta                 r_s1_meta;
    logic                  r_s1_valid;
    logic                  r_out_valid;
    logic [PIX_PORT_W-1:0] r_pix;
    logic [POS_W-1:0]      r_x, r_y;
    logic                  r_last;
    t_status               r_status;
    logic                  out_free, s1_go;

    assign out_free = !r_out_valid || !i_out_stall;
    assign s1_go    = r_s1_valid && out_free;
    assign o_pop    = !i_empty && (!r_s1_valid || s1_go);

    // store port: at most one write or one read per request
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_s1_meta <= i_meta;
            if (i_meta.kind == K_WRITE) begin
                r_store[i_addr] <= i_pix;
            end
            if (i_meta.kind == K_READ) begin
                r_rd <= r_store[i_addr];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_s1_valid <= 1'b1;
            end else if (s1_go) begin
                r_s1_valid <= 1'b0;
            end
            if (out_free) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_go) begin
            r_pix    <= (r_s1_meta.kind == K_READ) ? PIX_PORT_W'(r_rd) : '0;
            r_x      <= r_s1_meta.x;
            r_y      <= r_s1_meta.y;
            r_last   <= r_s1_meta.last;
            r_status <= r_s1_meta.status;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_pixel_out  = r_pix;
    assign o_out_x      = r_x;
    assign o_out_y      = r_y;
    assign o_last_pixel = r_last;
    assign o_status     = r_status;

endmodule

/* src/frame_window_crop_roll_resize.sv */
// ----------------------------------------------------------------------------
// frame_window_crop_roll_resize
// Frame store with nearest neighbour resize, circular roll and crop readout.
// ----------------------------------------------------------------------------
// Loads fill the frame store in raster order, one pixel per request; a load
// is pushed to the queue in the cycle it is accepted. Fetches return the
// output frame in raster order. A crop fetch goes from idle to the push
// state; a resize or roll fetch first runs the shared serial divider, which
// produces one quotient bit per cycle (14 bits), twice per pixel (column,
// then row). The front takes no new request until the fetch is pushed. The
// back reads or writes the single-port frame store at most once per request,
// and a result passes from the queue through the stage-one register to the
// output register. The store needs no clearing after reset.
module frame_window_crop_roll_resize #(
    parameter int MAX_WIDTH  = 64,
    parameter int MAX_HEIGHT = 64,
    parameter int PIXEL_BITS = 32
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [fwcrr_pkg::PADDR_W-1:0]    paddr,
    input  logic [fwcrr_pkg::PDATA_W-1:0]    pwdata,
    output logic [fwcrr_pkg::PDATA_W-1:0]    prdata,
    output logic                             pready,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic                             i_operation,
    input  logic [fwcrr_pkg::PIX_PORT_W-1:0] i_pixel_in,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic [fwcrr_pkg::PIX_PORT_W-1:0] o_pixel_out,
    output logic [fwcrr_pkg::POS_W-1:0]      o_out_x,
    output logic [fwcrr_pkg::POS_W-1:0]      o_out_y,
    output logic                             o_last_pixel,
    output logic [1:0]                       o_status
);
    import fwcrr_pkg::*;

    localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int Q_W    = META_W + ADDR_W + PIXEL_BITS;

    t_cfg                  r_cfg;
    logic                  cfg_wr;
    logic [REG_IDX_W-1:0]  reg_idx;

    logic                  f_push;
    t_meta                 f_meta;
    logic [ADDR_W-1:0]     f_addr;
    logic [PIXEL_BITS-1:0] f_pix;
    logic                  q_full, q_empty, q_pop;
    logic [Q_W-1:0]        q_rd;
    t_meta                 q_meta;
    logic [ADDR_W-1:0]     q_addr;
    logic [PIXEL_BITS-1:0] q_pix;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_idx = paddr[PADDR_W-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode       <= RST_MODE;
            r_cfg.src_width  <= RST_SIZE;
            r_cfg.src_height <= RST_SIZE;
            r_cfg.out_width  <= RST_SIZE;
            r_cfg.out_height <= RST_SIZE;
            r_cfg.offset_x   <= RST_OFFSET;
            r_cfg.offset_y   <= RST_OFFSET;
        end else if (cfg_wr) begin
            case (reg_idx)
                REG_MODE:       r_cfg.mode       <= pwdata[MODE_W-1:0];
                REG_SRC_WIDTH:  r_cfg.src_width  <= pwdata[CFG_W-1:0];
                REG_SRC_HEIGHT: r_cfg.src_height <= pwdata[CFG_W-1:0];
                REG_OUT_WIDTH:  r_cfg.out_width  <= pwdata[CFG_W-1:0];
                REG_OUT_HEIGHT: r_cfg.out_height <= pwdata[CFG_W-1:0];
                REG_OFFSET_X:   r_cfg.offset_x   <= pwdata[OFF_W-1:0];
                REG_OFFSET_Y:   r_cfg.offset_y   <= pwdata[OFF_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_MODE:       prdata = PDATA_W'(r_cfg.mode);
            REG_SRC_WIDTH:  prdata = PDATA_W'(r_cfg.src_width);
            REG_SRC_HEIGHT: prdata = PDATA_W'(r_cfg.src_height);
            REG_OUT_WIDTH:  prdata = PDATA_W'(r_cfg.out_width);
            REG_OUT_HEIGHT: prdata = PDATA_W'(r_cfg.out_height);
            REG_OFFSET_X:   prdata = PDATA_W'(r_cfg.offset_x);
            REG_OFFSET_Y:   prdata = PDATA_W'(r_cfg.offset_y);
            default:        prdata = '0;
        endcase
    end

    fwcrr_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .ADDR_W     (ADDR_W),
        .PIXEL_BITS (PIXEL_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_operation (i_operation),
        .i_pixel_in  (i_pixel_in),
        .o_push      (f_push),
        .o_meta      (f_meta),
        .o_addr      (f_addr),
        .o_pix       (f_pix),
        .i_full      (q_full)
    );

    fwcrr_queue #(
        .W     (Q_W),
        .DEPTH (4)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .i_data  ({f_meta, f_addr, f_pix}),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_data  (q_rd),
        .o_empty (q_empty)
    );

    assign q_meta = t_meta'(q_rd[Q_W-1 -: META_W]);
    assign q_addr = q_rd[PIXEL_BITS +: ADDR_W];
    assign q_pix  = q_rd[PIXEL_BITS-1:0];

    fwcrr_back #(
        .ADDR_W     (ADDR_W),
        .PIXEL_BITS (PIXEL_BITS),
        .DEPTH      (DEPTH)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_empty      (q_empty),
        .i_meta       (q_meta),
        .i_addr       (q_addr),
        .i_pix        (q_pix),
        .o_pop        (q_pop),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_pixel_out  (o_pixel_out),
        .o_out_x      (o_out_x),
        .o_out_y      (o_out_y),
        .o_last_pixel (o_last_pixel),
        .o_status     (o_status)
    );

    // queue never takes a request while full
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(f_push && q_full))
        else $error("request pushed into full queue");

    // only a delivered pixel carries pixel data
    a_zero_pixel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status != STAT_PIXEL) |-> (o_pixel_out == '0))
        else $error("non-pixel result with pixel data");

    // end of frame is flagged only on a delivered pixel
    a_last_pixel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_last_pixel) |-> (o_status == STAT_PIXEL))
        else $error("last pixel flag on non-pixel result");

endmodule

/* tb/tb_frame_window_crop_roll_resize.sv */
// ----------------------------------------------------------------------------
// tb_frame_window_crop_roll_resize
// Self-checking bench for the frame crop, roll and resize engine.
// ----------------------------------------------------------------------------
// Frames are loaded over the request channel and read back under every mode.
// Registers go in over the APB port while the block is idle. A scoreboard
// class keeps its own copy of the frame store, position and registers, works
// out the result owed for every accepted request and checks results in
// order. Both channels idle at random: the sender in bursts, the receiver on
// a stall pattern that changes its rate over time.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_frame_window_crop_roll_resize;
    import fwcrr_pkg::*;

    localparam int MAX_W          = 64;
    localparam int MAX_H          = 64;
    localparam int FRAME_DEPTH    = MAX_W * MAX_H;
    localparam int RANDOM_ITEMS   = 250;
    localparam int WATCHDOG_LIMIT = 4000;

    typedef struct {
        logic [PIX_PORT_W-1:0] pixel;
        logic [POS_W-1:0]      x;
        logic [POS_W-1:0]      y;
        logic                  last;
        t_status               status;
    } t_remap_result;

    class remap_scoreboard;
        logic [PIX_PORT_W-1:0] frame [FRAME_DEPTH];
        bit                    filled[FRAME_DEPTH];
        int unsigned           loaded;
        int unsigned           col;
        int unsigned           row;
        bit                    frame_ready;
        t_cfg                  cfg;
        t_remap_result         due_pixels[$];
        int unsigned           mismatches;

        function new();
            loaded          = 0;
            col             = 0;
            row             = 0;
            frame_ready     = 1'b0;
            mismatches      = 0;
            cfg.mode        = RST_MODE;
            cfg.src_width   = RST_SIZE;
            cfg.src_height  = RST_SIZE;
            cfg.out_width   = RST_SIZE;
            cfg.out_height  = RST_SIZE;
            cfg.offset_x    = RST_OFFSET;
            cfg.offset_y    = RST_OFFSET;
        endfunction

        function int unsigned clamp_size(int unsigned v, int unsigned lo, int unsigned hi);
            if (v < lo) return lo;
            return (v > hi) ? hi : v;
        endfunction

        function void set_reg(logic [REG_IDX_W-1:0] idx, logic [PDATA_W-1:0] value);
            case (idx)
                REG_MODE:       cfg.mode       = value[MODE_W-1:0];
                REG_SRC_WIDTH:  cfg.src_width  = value[CFG_W-1:0];
                REG_SRC_HEIGHT: cfg.src_height = value[CFG_W-1:0];
                REG_OUT_WIDTH:  cfg.out_width  = value[CFG_W-1:0];
                REG_OUT_HEIGHT: cfg.out_height = value[CFG_W-1:0];
                REG_OFFSET_X:   cfg.offset_x   = value[OFF_W-1:0];
                REG_OFFSET_Y:   cfg.offset_y   = value[OFF_W-1:0];
                default: ;
            endcase
        endfunction

        // where the next fetch would read from, and at which output position
        function t_status locate(output int unsigned idx, output int unsigned ow,
                                 output int unsigned oh, output int unsigned c,
                                 output int unsigned r);
            int unsigned sw, sh, sx, sy;
            bit          crop, roll;
            sw   = clamp_size(cfg.src_width, 1, MAX_W);
            sh   = clamp_size(cfg.src_height, 1, MAX_H);
            ow   = clamp_size(cfg.out_width, 0, MAX_W);
            oh   = clamp_size(cfg.out_height, 0, MAX_H);
            crop = cfg.mode[MODE_CROP_BIT];
            roll = !crop && ((cfg.mode & MODE_ROLL) != '0);
            idx  = 0;
            c    = 0;
            r    = 0;
            if (!frame_ready) return STAT_INCOMPLETE;
            if (crop) begin
                if (ow == 0 || oh == 0 || cfg.offset_x + ow > sw || cfg.offset_y + oh > sh)
                    return STAT_INVALID;
            end else if (roll) begin
                ow = sw;
                oh = sh;
            end else if (ow == 0 || oh == 0) begin
                return STAT_INVALID;
            end
            if (col < ow && row < oh) begin
                c = col;
                r = row;
            end
            if (crop) begin
                sx = c + cfg.offset_x;
                sy = r + cfg.offset_y;
            end else if (roll) begin
                sx = (c + cfg.offset_x) % sw;
                sy = (r + cfg.offset_y) % sh;
            end else begin
                sx = (c * sw) / ow;
                sy = (r * sh) / oh;
            end
            idx = sy * sw + sx;
            return STAT_PIXEL;
        endfunction

        function bit fetch_safe();
            int unsigned idx, ow, oh, c, r;
            if (locate(idx, ow, oh, c, r) != STAT_PIXEL) return 1'b1;
            return filled[idx];
        endfunction

        function int unsigned out_pixels();
            int unsigned idx, ow, oh, c, r;
            if (locate(idx, ow, oh, c, r) != STAT_PIXEL) return 4;
            return ow * oh;
        endfunction

        function void note_request(logic op, logic [PIX_PORT_W-1:0] pixel);
            t_remap_result res;
            int unsigned   frame_size, idx, ow, oh, c, r;
            res = '{pixel: '0, x: '0, y: '0, last: 1'b0, status: STAT_LOADED};
            if (op == OP_LOAD) begin
                frame_size = clamp_size(cfg.src_width, 1, MAX_W)
                           * clamp_size(cfg.src_height, 1, MAX_H);
                if (frame_ready || loaded >= frame_size) begin
                    frame_ready = 1'b0;
                    loaded      = 0;
                end
                frame[loaded]  = pixel;
                filled[loaded] = 1'b1;
                loaded++;
                if (loaded >= frame_size) begin
                    frame_ready = 1'b1;
                    loaded      = 0;
                end
                col = 0;
                row = 0;
            end else begin
                res.status = locate(idx, ow, oh, c, r);
                if (res.status == STAT_PIXEL) begin
                    res.pixel = frame[idx];
                    res.x     = POS_W'(c);
                    res.y     = POS_W'(r);
                    res.last  = (c + 1 == ow) && (r + 1 == oh);
                    if (res.last) begin
                        c = 0;
                        r = 0;
                    end else if (c + 1 >= ow) begin
                        c = 0;
                        r++;
                    end else begin
                        c++;
                    end
                    col = c;
                    row = r;
                end
            end
            due_pixels.push_back(res);
        endfunction

        function void check_pixel(logic [PIX_PORT_W-1:0] pixel, logic [POS_W-1:0] x,
                                  logic [POS_W-1:0] y, logic last, logic [1:0] status);
            t_remap_result e;
            if (due_pixels.size() == 0) begin
                $error("result with no request owed: status %0d", status);
                mismatches++;
                return;
            end
            e = due_pixels.pop_front();
            if (pixel !== e.pixel) begin
                $error("pixel_out: expected %h, got %h", e.pixel, pixel);
                mismatches++;
            end
            if (x !== e.x) begin
                $error("out_x: expected %0d, got %0d", e.x, x);
                mismatches++;
            end
            if (y !== e.y) begin
                $error("out_y: expected %0d, got %0d", e.y, y);
                mismatches++;
            end
            if (last !== e.last) begin
                $error("last_pixel: expected %0d, got %0d", e.last, last);
                mismatches++;
            end
            if (status !== e.status) begin
                $error("status: expected %0d, got %0d", e.status, status);
                mismatches++;
            end
        endfunction

        function int unsigned pending();
            return due_pixels.size();
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [PADDR_W-1:0]    paddr;
    logic [PDATA_W-1:0]    pwdata;
    logic [PDATA_W-1:0]    prdata;
    logic                  pready;
    logic                  i_in_valid;
    logic                  o_in_stall;
    logic                  i_operation;
    logic [PIX_PORT_W-1:0] i_pixel_in;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    logic [PIX_PORT_W-1:0] o_pixel_out;
    logic [POS_W-1:0]      o_out_x;
    logic [POS_W-1:0]      o_out_y;
    logic                  o_last_pixel;
    logic [1:0]            o_status;

    remap_scoreboard sb = new();
    int              burst_left    = 0;
    int              requests_sent = 0;
    int              idle_cycles   = 0;
    int              stall_pct     = 0;
    int              stall_hold    = 0;
    int              random_start;

    frame_window_crop_roll_resize #(
        .MAX_WIDTH  (MAX_W),
        .MAX_HEIGHT (MAX_H),
        .PIXEL_BITS (PIX_PORT_W)
    ) i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_operation  (i_operation),
        .i_pixel_in   (i_pixel_in),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_pixel_out  (o_pixel_out),
        .o_out_x      (o_out_x),
        .o_out_y      (o_out_y),
        .o_last_pixel (o_last_pixel),
        .o_status     (o_status)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // result checking, receiver stall pattern and idle count
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_out_valid === 1'b1 && i_out_stall == 1'b0) begin
            sb.check_pixel(o_pixel_out, o_out_x, o_out_y, o_last_pixel, o_status);
        end
        if ((i_in_valid === 1'b1 && o_in_stall === 1'b0) ||
            (o_out_valid === 1'b1 && i_out_stall == 1'b0)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (stall_hold == 0) begin
            case ($urandom_range(4))
                0, 1:    stall_pct = 0;
                2:       stall_pct = 25;
                3:       stall_pct = 60;
                default: stall_pct = 90;
            endcase
            stall_hold = $urandom_range(20, 120);
        end else begin
            stall_hold--;
        end
        i_out_stall <= ($urandom_range(99) < stall_pct);
    end

    initial begin
        while (idle_cycles < WATCHDOG_LIMIT) @(posedge i_clk);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    task automatic send_request(input logic op, input logic [PIX_PORT_W-1:0] pixel);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = ($urandom_range(4) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 12);
        end
        // never fetch from a store entry that was not loaded
        if (op == OP_FETCH && !sb.fetch_safe()) op = OP_LOAD;
        i_in_valid  <= 1'b1;
        i_operation <= op;
        i_pixel_in  <= pixel;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        sb.note_request(op, pixel);
        burst_left--;
        requests_sent++;
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        burst_left = 0;
        do @(posedge i_clk); while (sb.pending() != 0);
    endtask

    task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input int unsigned value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= PDATA_W'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        sb.set_reg(idx, PDATA_W'(value));
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_frame(input int unsigned m, input int unsigned sw, input int unsigned sh,
                             input int unsigned ow, input int unsigned oh,
                             input int unsigned ox, input int unsigned oy);
        drain();
        write_reg(REG_MODE, m);
        write_reg(REG_SRC_WIDTH, sw);
        write_reg(REG_SRC_HEIGHT, sh);
        write_reg(REG_OUT_WIDTH, ow);
        write_reg(REG_OUT_HEIGHT, oh);
        write_reg(REG_OFFSET_X, ox);
        write_reg(REG_OFFSET_Y, oy);
    endtask

    task automatic load_frame();
        do send_request(OP_LOAD, $urandom()); while (!sb.frame_ready);
    endtask

    function automatic int unsigned pick_out_size();
        case ($urandom_range(9))
            0:       return 0;
            1:       return $urandom_range(65, 127);
            2:       return MAX_W;
            default: return $urandom_range(1, 9);
        endcase
    endfunction

    task automatic random_phase();
        int unsigned       w, h, cw, ch, ow, oh, ox, oy, n;
        logic [MODE_W-1:0] m;
        m = MODE_W'($urandom());
        case ($urandom_range(9))
            0: begin
                w = $urandom_range(64, 127);
                h = $urandom_range(0, 2);
            end
            1: begin
                w = $urandom_range(0, 2);
                h = $urandom_range(64, 127);
            end
            default: begin
                w = $urandom_range(0, 7);
                h = $urandom_range(0, 7);
            end
        endcase
        cw = (w == 0) ? 1 : ((w > MAX_W) ? MAX_W : w);
        ch = (h == 0) ? 1 : ((h > MAX_H) ? MAX_H : h);
        ow = pick_out_size();
        oh = pick_out_size();
        ox = ($urandom_range(3) == 0) ? $urandom_range(63) : $urandom_range(3);
        oy = ($urandom_range(3) == 0) ? $urandom_range(63) : $urandom_range(3);
        // mostly a crop window that fits the source
        if (m[MODE_CROP_BIT] && $urandom_range(3) != 0) begin
            ow = $urandom_range(1, cw);
            oh = $urandom_range(1, ch);
            ox = $urandom_range(0, cw - ow);
            oy = $urandom_range(0, ch - oh);
        end
        set_frame(m, w, h, ow, oh, ox, oy);
        case ($urandom_range(9))
            7: ;
            8: repeat ($urandom_range(1, 3)) send_request(OP_LOAD, $urandom());
            9: begin
                repeat ($urandom_range(1, 12))
                    send_request(($urandom_range(1) == 0) ? OP_LOAD : OP_FETCH, $urandom());
            end
            default: load_frame();
        endcase
        n = sb.out_pixels() + 2;
        if (n > 40) n = 40;
        repeat ($urandom_range(1, n)) send_request(OP_FETCH, $urandom());
    endtask

    initial begin
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_operation <= OP_LOAD;
        i_pixel_in  <= '0;
        psel        <= 1'b0;
        penable     <= 1'b0;
        pwrite      <= 1'b0;
        paddr       <= '0;
        pwdata      <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // fetch before any frame is complete
        send_request(OP_FETCH, $urandom());
        send_request(OP_LOAD, 32'hFFFF_FFFF);

        // zero source width saturates to one, roll by the largest shifts
        set_frame(MODE_ROLL, 0, 2, MAX_W, MAX_H, 63, 63);
        send_request(OP_LOAD, 32'h0000_0000);
        repeat (3) send_request(OP_FETCH, $urandom());

        // mode three decodes as crop: empty window, then window past the source
        set_frame(MODE_CROP | MODE_ROLL, 0, 2, 0, 2, 0, 0);
        send_request(OP_FETCH, $urandom());
        set_frame(MODE_CROP | MODE_ROLL, 0, 2, 127, 1, 0, 0);
        send_request(OP_FETCH, $urandom());

        // whole-frame crop, fetched past the last pixel
        set_frame(MODE_CROP, 1, 2, 1, 2, 0, 0);
        repeat (3) send_request(OP_FETCH, $urandom());

        // resize with zero width, then upscale and shrink the output mid-frame
        set_frame(MODE_RESIZE, 1, 2, 0, MAX_H, 0, 0);
        send_request(OP_FETCH, $urandom());
        set_frame(MODE_RESIZE, 1, 2, MAX_W, MAX_H, 0, 0);
        repeat (3) send_request(OP_FETCH, $urandom());
        set_frame(MODE_RESIZE, 1, 2, 2, MAX_H, 0, 0);
        send_request(OP_FETCH, $urandom());

        // source shrunk below the load count restarts the frame
        set_frame(MODE_RESIZE, 3, 1, 2, MAX_H, 0, 0);
        repeat (2) send_request(OP_LOAD, $urandom());
        set_frame(MODE_RESIZE, 1, 1, 2, MAX_H, 0, 0);
        send_request(OP_LOAD, $urandom());
        send_request(OP_FETCH, $urandom());

        // widest and tallest sources with the window at the far edge
        set_frame(MODE_CROP, 127, 1, 1, 1, 63, 0);
        load_frame();
        repeat (2) send_request(OP_FETCH, $urandom());
        set_frame(MODE_CROP, 1, MAX_H, 1, 1, 0, 63);
        load_frame();
        repeat (2) send_request(OP_FETCH, $urandom());

        random_start = requests_sent;
        while (requests_sent - random_start < RANDOM_ITEMS) random_phase();

        drain();
        repeat (64) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

/* files.f */
src/fwcrr_pkg.sv
src/fwcrr_div.sv
src/fwcrr_front.sv
src/fwcrr_queue.sv
src/fwcrr_back.sv
src/frame_window_crop_roll_resize.sv
tb/tb_frame_window_crop_roll_resize.sv
